// File: rtl/assert_macros.svh
// Assertion macros shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define DART_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("timer assertion failed");

// Clocked check that must also hold while reset is held.
`define DART_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("timer assertion failed");

`endif

// File: rtl/dart_pkg.sv
package dart_pkg;

    // Request kinds.
    localparam logic [1:0] REQ_ADVANCE = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_WRITE   = 2'd2;

    // Register addresses.
    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA = 16'hFF05;
    localparam logic [15:0] ADDR_TMA  = 16'hFF06;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;

    // Rate selections held in the low two control bits.
    localparam logic [1:0] RATE_1024 = 2'd0;
    localparam logic [1:0] RATE_16   = 2'd1;
    localparam logic [1:0] RATE_64   = 2'd2;
    localparam logic [1:0] RATE_256  = 2'd3;

    localparam int TAC_EN_BIT = 2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  cycle_count;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_req;

    // Mask of prescaler bits that lie below the selected period.
    function automatic logic [9:0] period_mask(input logic [1:0] rate);
        logic [9:0] mask;
        case (rate)
            RATE_1024: mask = 10'h3FF;
            RATE_16:   mask = 10'h00F;
            RATE_64:   mask = 10'h03F;
            RATE_256:  mask = 10'h0FF;
            default:   mask = 10'h3FF;
        endcase
        return mask;
    endfunction

endpackage

// File: rtl/dart_regs.sv
`include "assert_macros.svh"

module dart_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  dart_pkg::t_req     i_req,
    output logic [7:0]         o_read_data
);

    logic [15:0] r_div_cnt;
    logic [7:0]  r_tima;
    logic [9:0]  r_prescale;
    logic [7:0]  r_tma;
    logic [2:0]  r_tac;

    logic [15:0] n_div_cnt;
    logic [7:0]  n_tima;
    logic [9:0]  n_prescale;
    logic [7:0]  n_tma;
    logic [2:0]  n_tac;

    logic [10:0] sum;
    logic [6:0]  ticks;
    logic [9:0]  remainder;
    logic [8:0]  tima_next;

    // Prescaler plus elapsed cycles, split into whole ticks and leftover cycles.
    always_comb begin
        sum = {1'b0, r_prescale} + {3'b000, i_req.cycle_count};
        case (r_tac[1:0])
            dart_pkg::RATE_1024: begin
                ticks     = {6'b0, sum[10]};
                remainder = sum[9:0];
            end
            dart_pkg::RATE_16: begin
                ticks     = sum[10:4];
                remainder = {6'b0, sum[3:0]};
            end
            dart_pkg::RATE_64: begin
                ticks     = {2'b0, sum[10:6]};
                remainder = {4'b0, sum[5:0]};
            end
            dart_pkg::RATE_256: begin
                ticks     = {4'b0, sum[10:8]};
                remainder = {2'b0, sum[7:0]};
            end
            default: begin
                ticks     = {6'b0, sum[10]};
                remainder = sum[9:0];
            end
        endcase
        tima_next = {1'b0, r_tima} + {2'b00, ticks};
    end

    always_comb begin
        n_div_cnt  = r_div_cnt;
        n_tima     = r_tima;
        n_prescale = r_prescale;
        n_tma      = r_tma;
        n_tac      = r_tac;
        case (i_req.req_type)
            dart_pkg::REQ_ADVANCE: begin
                n_div_cnt = r_div_cnt + {8'h00, i_req.cycle_count};
                if (r_tac[dart_pkg::TAC_EN_BIT]) begin
                    // Any carry out of TIMA reloads it and drops what is left over.
                    if (tima_next[8]) begin
                        n_tima     = r_tma;
                        n_prescale = '0;
                    end else begin
                        n_tima     = tima_next[7:0];
                        n_prescale = remainder;
                    end
                end
            end
            dart_pkg::REQ_WRITE: begin
                case (i_req.bus_address)
                    dart_pkg::ADDR_DIV: begin
                        n_div_cnt = '0;
                    end
                    dart_pkg::ADDR_TIMA: begin
                        n_tima     = i_req.write_data;
                        n_prescale = '0;
                    end
                    dart_pkg::ADDR_TMA: begin
                        n_tma = i_req.write_data;
                    end
                    dart_pkg::ADDR_TAC: begin
                        n_tac      = i_req.write_data[2:0];
                        n_prescale = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_read_data = '0;
        if (i_req.req_type == dart_pkg::REQ_READ) begin
            case (i_req.bus_address)
                dart_pkg::ADDR_DIV:  o_read_data = r_div_cnt[15:8];
                dart_pkg::ADDR_TIMA: o_read_data = r_tima;
                dart_pkg::ADDR_TMA:  o_read_data = r_tma;
                dart_pkg::ADDR_TAC:  o_read_data = {5'b00000, r_tac};
                default:             o_read_data = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt  <= '0;
            r_tima     <= '0;
            r_prescale <= '0;
            r_tma      <= '0;
            r_tac      <= '0;
        end else if (i_en) begin
            r_div_cnt  <= n_div_cnt;
            r_tima     <= n_tima;
            r_prescale <= n_prescale;
            r_tma      <= n_tma;
            r_tac      <= n_tac;
        end
    end

    `DART_ASSERT(a_prescale_below_period, i_clk, i_rst_n,
        (r_prescale & ~dart_pkg::period_mask(r_tac[1:0])) == 10'h000)
    `DART_ASSERT(a_div_write_clears, i_clk, i_rst_n,
        i_en && i_req.req_type == dart_pkg::REQ_WRITE
        && i_req.bus_address == dart_pkg::ADDR_DIV |=> r_div_cnt == 16'h0000)

endmodule

// File: rtl/divider_and_reloading_timer.sv
// Divider and reloading timer with DIV, TIMA, TMA and TAC registers.
// Requests arrive on the input channel (i_valid / o_stall): an advance of
// i_cycle_count cycles, a register read or a register write at
// i_bus_address. A transfer takes place at a rising edge with valid high
// and stall low. Every request yields exactly one result transfer on the
// output channel (o_valid / i_stall) carrying o_read_data, which is the
// register byte for a read and zero otherwise.
// A request is held in an input register; its state update and read
// data are formed by adders, a shift selected by the TAC rate and a carry
// check, and the result is captured in an output register, which drives
// o_valid. One request per cycle is sustained while the receiver does not
// stall; the single timer register set is updated as each request passes
// into the output register.
// When the receiver stalls, the result is held and one further request
// may still be taken into the input register; o_stall rises only when both
// registers are full and the output is stalled.
// Synchronous reset clears every timer register (timer off, divide by
// 1024) and empties both pipeline registers.
`include "assert_macros.svh"

module divider_and_reloading_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_cycle_count,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data
);

    logic           r_in_valid;
    dart_pkg::t_req r_req;
    logic           r_out_valid;
    logic [7:0]     r_read_data;

    logic           advance;
    logic           in_load;
    logic [7:0]     read_data;

    // The stored request moves on whenever the output register is free or
    // is being emptied by a transfer in this cycle.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_load = i_valid && !o_stall;

    dart_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_req       (r_req),
        .o_read_data (read_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_req.req_type    <= i_req_type;
            r_req.cycle_count <= i_cycle_count;
            r_req.bus_address <= i_bus_address;
            r_req.write_data  <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data <= read_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;

    `DART_ASSERT(a_full_stall_keeps_both, i_clk, i_rst_n,
        r_in_valid && r_out_valid && i_stall |=> r_in_valid && r_out_valid)
    `DART_ASSERT(a_result_has_source, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_in_valid))
    `DART_ASSERT_ALWAYS(a_reset_empties, i_clk,
        !i_rst_n |=> !r_in_valid && !r_out_valid)

endmodule

// File: bench/divider_and_reloading_timer_checker.sv
`timescale 1ns / 1ps

module divider_and_reloading_timer_checker
    import dart_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_cycle_count,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  logic [7:0]  i_read_data,
    output int          o_fail_count,
    output int          o_pending
);

    // Timer state as this checker believes it to be.
    logic [15:0] div_cycles;
    logic [7:0]  tima_value;
    logic [9:0]  prescale;
    logic [7:0]  tma_value;
    logic [2:0]  tac_value;

    logic [7:0]  read_data_q[$];
    logic [7:0]  expected_byte;
    int          fail_count = 0;
    int          pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic int unsigned tick_period(input logic [1:0] rate);
        int unsigned period;
        period = 1024;
        case (rate)
            RATE_1024: period = 1024;
            RATE_16:   period = 16;
            RATE_64:   period = 64;
            RATE_256:  period = 256;
        endcase
        return period;
    endfunction

    // Applies one request to the timer state and returns the byte it reads.
    function automatic logic [7:0] apply_request(input logic [1:0] kind,
                                                 input logic [7:0] cycles,
                                                 input logic [15:0] addr,
                                                 input logic [7:0] data);
        int unsigned period;
        int unsigned sum;
        int unsigned next;
        logic [7:0]  rd;
        rd = 8'h00;
        if (kind == REQ_ADVANCE) begin
            div_cycles = div_cycles + 16'(cycles);
            if (tac_value[TAC_EN_BIT]) begin
                period = tick_period(tac_value[1:0]);
                sum    = prescale + cycles;
                next   = tima_value + sum / period;
                // A carry past 255 drops whatever ticks and cycles remain.
                if (next > 255) begin
                    tima_value = tma_value;
                    prescale   = 10'd0;
                end else begin
                    tima_value = next[7:0];
                    prescale   = 10'(sum % period);
                end
            end
        end else if (kind == REQ_READ) begin
            case (addr)
                ADDR_DIV:  rd = div_cycles[15:8];
                ADDR_TIMA: rd = tima_value;
                ADDR_TMA:  rd = tma_value;
                ADDR_TAC:  rd = {5'd0, tac_value};
                default:   rd = 8'h00;
            endcase
        end else if (kind == REQ_WRITE) begin
            case (addr)
                ADDR_DIV:  div_cycles = 16'd0;
                ADDR_TIMA: begin
                    tima_value = data;
                    prescale   = 10'd0;
                end
                ADDR_TMA:  tma_value = data;
                ADDR_TAC:  begin
                    tac_value = data[2:0];
                    prescale  = 10'd0;
                end
                default:   ;
            endcase
        end
        return rd;
    endfunction

    function automatic void note_failure(input string what, input logic [7:0] exp_byte,
                                         input logic [7:0] act_byte);
        if (fail_count < 10)
            $display("[%0t] %s: expected read_data %02h, got %02h",
                     $realtime, what, exp_byte, act_byte);
        fail_count++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            div_cycles = 16'd0;
            tima_value = 8'd0;
            prescale   = 10'd0;
            tma_value  = 8'd0;
            tac_value  = 3'd0;
            read_data_q.delete();
            pending = 0;
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (read_data_q.size() == 0) begin
                    note_failure("result transfer with nothing outstanding", 8'h00,
                                 i_read_data);
                end else begin
                    expected_byte = read_data_q.pop_front();
                    if (i_read_data !== expected_byte)
                        note_failure("read_data mismatch", expected_byte, i_read_data);
                end
            end
            if (i_req_valid && !i_req_stall)
                read_data_q.push_back(apply_request(i_req_type, i_cycle_count,
                                                    i_bus_address, i_write_data));
            pending = read_data_q.size();
        end
    end

endmodule

// File: bench/tb_divider_and_reloading_timer.sv
`timescale 1ns / 1ps

module tb_divider_and_reloading_timer;
    import dart_pkg::*;

    // The block accepts a fourth request kind and treats it as a no-op.
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Generous bound: every transfer may see the longest gap drawn on the
    // sending side and the longest stall on the receiving side, plus the
    // pipeline, for roughly two thousand requests. Taken many times over.
    localparam int CYCLE_LIMIT = 500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        req_valid = 1'b0;
    logic [1:0]  req_type = REQ_ADVANCE;
    logic [7:0]  cycle_count = 8'd0;
    logic [15:0] bus_address = 16'd0;
    logic [7:0]  write_data = 8'd0;
    logic        req_stall;

    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [7:0]  read_data;

    int          fail_count;
    int          pending;
    int          run_cycles = 0;

    // When set, neither side inserts gaps or stalls, so that back-to-back
    // transfers are exercised as well as ragged traffic.
    bit          no_idle = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    divider_and_reloading_timer u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_req_type   (req_type),
        .i_cycle_count(cycle_count),
        .i_bus_address(bus_address),
        .i_write_data (write_data),
        .o_valid      (rsp_valid),
        .i_stall      (rsp_stall),
        .o_read_data  (read_data)
    );

    divider_and_reloading_timer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req_type   (req_type),
        .i_cycle_count(cycle_count),
        .i_bus_address(bus_address),
        .i_write_data (write_data),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_read_data  (read_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // A hung handshake must not leave the run spinning for ever.
    always @(posedge clk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles >= CYCLE_LIMIT) begin
            $display("tb_divider_and_reloading_timer: FAIL");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(10);
    endfunction

    // Presents one request and returns at the rising edge that accepts it.
    // Valid is only lowered when a gap is drawn, so it is never dropped and
    // raised again within one time step.
    task automatic send_request(input logic [1:0] kind, input logic [7:0] cycles,
                                input logic [15:0] addr, input logic [7:0] data);
        int gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= kind;
        cycle_count <= cycles;
        bus_address <= addr;
        write_data  <= data;
        do @(posedge clk); while (req_stall);
    endtask

    // Builds one random request. In the advance-heavy flavour time moves on
    // far enough for the divider to wrap and TIMA to overflow repeatedly, so
    // clearing DIV is held back there.
    task automatic send_random_request(input bit advance_heavy);
        int          roll;
        logic [1:0]  kind;
        logic [7:0]  cycles;
        logic [15:0] addr;
        roll = $urandom_range(99);
        if (advance_heavy)
            kind = (roll < 80) ? REQ_ADVANCE : (roll < 90) ? REQ_READ :
                   (roll < 98) ? REQ_WRITE : REQ_NONE;
        else
            kind = (roll < 45) ? REQ_ADVANCE : (roll < 70) ? REQ_READ :
                   (roll < 95) ? REQ_WRITE : REQ_NONE;

        // Cycle counts favour the two extremes now and then.
        if ($urandom_range(9) == 0)
            cycles = $urandom_range(1) ? 8'd255 : 8'd0;
        else
            cycles = 8'($urandom_range(255));

        // Mostly the four timer registers; the rest anywhere in the map.
        if ($urandom_range(4) == 0) begin
            addr = 16'($urandom);
        end else begin
            case ($urandom_range(3))
                0:       addr = ADDR_DIV;
                1:       addr = ADDR_TIMA;
                2:       addr = ADDR_TMA;
                default: addr = ADDR_TAC;
            endcase
        end
        if (advance_heavy && kind == REQ_WRITE && addr == ADDR_DIV)
            addr = ADDR_TMA;

        send_request(kind, cycles, addr, 8'($urandom_range(255)));
    endtask

    // Receiving side: a fresh stall length is drawn for every result transfer.
    initial begin
        int hold;
        wait (rst_n === 1'b1);
        forever begin
            hold = idle_cycles();
            @(negedge clk);
            if (hold > 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: registers straight after reset, an overflowing
        // advance that reloads from TMA, clearing DIV while ignoring the
        // byte, TAC losing its upper bits, advances with the timer off, the
        // spare request kind, and accesses outside the register map.
        send_request(REQ_READ,    8'd0,   ADDR_DIV,  8'h00);
        send_request(REQ_READ,    8'd0,   ADDR_TIMA, 8'h00);
        send_request(REQ_READ,    8'd0,   ADDR_TMA,  8'h00);
        send_request(REQ_READ,    8'd0,   ADDR_TAC,  8'h00);
        send_request(REQ_WRITE,   8'd0,   ADDR_TMA,  8'hFF);
        send_request(REQ_WRITE,   8'd0,   ADDR_TIMA, 8'hFE);
        send_request(REQ_WRITE,   8'd0,   ADDR_TAC,  8'h05);
        send_request(REQ_ADVANCE, 8'd255, ADDR_DIV,  8'h00);
        send_request(REQ_READ,    8'd0,   ADDR_TIMA, 8'h00);
        send_request(REQ_ADVANCE, 8'd255, ADDR_TAC,  8'hFF);
        send_request(REQ_READ,    8'd0,   ADDR_DIV,  8'h00);
        send_request(REQ_WRITE,   8'd0,   ADDR_DIV,  8'hFF);
        send_request(REQ_READ,    8'd0,   ADDR_DIV,  8'h00);
        send_request(REQ_WRITE,   8'd0,   ADDR_TAC,  8'hF8);
        send_request(REQ_READ,    8'd0,   ADDR_TAC,  8'h00);
        send_request(REQ_ADVANCE, 8'd255, ADDR_TIMA, 8'h00);
        send_request(REQ_READ,    8'd0,   ADDR_TIMA, 8'h00);
        send_request(REQ_NONE,    8'd255, ADDR_TIMA, 8'hFF);
        send_request(REQ_WRITE,   8'd0,   16'h0000,  8'hFF);
        send_request(REQ_READ,    8'd0,   16'hFFFF,  8'h00);
        send_request(REQ_WRITE,   8'd0,   ADDR_TAC,  8'h07);
        send_request(REQ_WRITE,   8'd0,   ADDR_TIMA, 8'h00);
        send_request(REQ_ADVANCE, 8'd0,   ADDR_TMA,  8'h00);
        send_request(REQ_READ,    8'd0,   ADDR_TAC,  8'h00);
        send_request(REQ_ADVANCE, 8'd255, ADDR_TIMA, 8'h00);

        // Random traffic in three phases; the middle one is advance-heavy.
        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < 650; n++) begin
                if (n % 100 == 0)
                    no_idle = ($urandom_range(3) == 0);
                send_random_request(phase == 1);
            end
        end
        no_idle = 1'b0;

        @(negedge clk);
        req_valid <= 1'b0;

        // Drain: wait for every outstanding result, then a few more cycles
        // so that any stray transfer from the block is still caught.
        while (pending != 0) @(negedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_divider_and_reloading_timer: PASS");
        else
            $display("tb_divider_and_reloading_timer: FAIL");
        $finish;
    end

endmodule
